/* sv/plc_pkg.sv */
// Shared constants, codes and types for the positional list editor.
// Depends on nothing; every other file refers to it by scoped names.
package plc_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 16;
   localparam int POS_W    = 16;
   localparam int OP_W     = 3;

   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_ERASE  = 3'd1;
   localparam logic [OP_W-1:0] OP_PRINT  = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
   localparam logic [OP_W-1:0] OP_SHOW   = 3'd4;

   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_ROTATE = 2'd2;

   typedef struct packed {
      logic [1:0]        mode;
      logic [IDX_W-1:0]  ins_idx;
      logic [DATA_W-1:0] ins_value;
      logic [IDX_W-1:0]  write_idx;
      logic              keep;
      logic [DATA_W-1:0] head;
   } cell_ctrl_type;

endpackage

/* sv/plc_req_if.sv */
// Request channel of the positional list editor: valid/ready plus payload.
// Depends on plc_pkg for the field widths.
interface plc_req_if;
   logic                       valid;
   logic                       ready;
   logic [plc_pkg::OP_W-1:0]   op;
   logic [plc_pkg::POS_W-1:0]  position;
   logic [plc_pkg::POS_W-1:0]  end_position;
   logic [plc_pkg::DATA_W-1:0] value;

   modport source (output valid, op, position, end_position, value, input ready);
   modport sink   (input valid, op, position, end_position, value, output ready);
endinterface

/* sv/plc_rsp_if.sv */
// Response channel of the positional list editor: valid/ready plus payload.
// Depends on plc_pkg for the field widths.
interface plc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [plc_pkg::DATA_W-1:0] item_value;
   logic                       last_item;
   logic                       status;

   modport source (output valid, item_value, last_item, status, input ready);
   modport sink   (input valid, item_value, last_item, status, output ready);
endinterface

/* sv/positional_list_editor.sv */
// Positional list editor: ordered list of up to plc_pkg::CAPACITY 16-bit entries in a cell row.
// Insert writes its entry into the row on acceptance; an insert into a full list goes to a full
// state that registers its status response (held back while an earlier response is still held).
// Erase, remove, print and show rotate the whole list one entry per cycle; a request that is
// skipped or finds the list empty is done on acceptance; each step holds while a response waits.
// Reset clears the length and control state; cell contents are left as they are.
module positional_list_editor (
   input  logic      clock,
   input  logic      reset,
   plc_req_if.sink   req_chan,
   plc_rsp_if.source rsp_chan
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PASS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam int CNT_W  = plc_pkg::CNT_W;
   localparam int IDX_W  = plc_pkg::IDX_W;
   localparam int DATA_W = plc_pkg::DATA_W;
   localparam int POS_W  = plc_pkg::POS_W;

   // control state
   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0] kept_ff, kept_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // operation context, captured with the request
   logic [plc_pkg::OP_W-1:0] op_ff, op_in;
   logic [CNT_W-1:0]         first_ff, first_in;
   logic [CNT_W-1:0]         stop_ff, stop_in;
   logic [DATA_W-1:0]        val_ff, val_in;

   // response payload
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_status_ff, rsp_status_in;

   logic              accept;
   logic              out_free;
   logic              is_full;
   logic [POS_W-1:0]  len_ext;
   logic [IDX_W-1:0]  ins_idx;
   logic              erase_skip;
   logic [CNT_W-1:0]  erase_stop;
   logic [CNT_W-1:0]  print_idx;
   logic              step;
   logic              keep;
   logic              emit;
   logic              last_step;
   logic              in_range;
   logic [CNT_W-1:0]  write_cnt;
   logic [CNT_W-1:0]  kept_next;
   logic [DATA_W-1:0] head;

   plc_pkg::cell_ctrl_type ctrl;

   logic [DATA_W-1:0] cell_value [plc_pkg::CAPACITY];
   logic [DATA_W-1:0] left_value [plc_pkg::CAPACITY];
   logic [DATA_W-1:0] right_value [plc_pkg::CAPACITY];

   // row of cells; the ends see zero from the missing neighbor
   for (genvar i = 0; i < plc_pkg::CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_value[i] = '0;
      end else begin : g_left
         assign left_value[i] = cell_value[i-1];
      end
      if (i == plc_pkg::CAPACITY - 1) begin : g_last
         assign right_value[i] = '0;
      end else begin : g_right
         assign right_value[i] = cell_value[i+1];
      end

      plc_cell u_cell (
         .clock       (clock),
         .cell_idx    (IDX_W'(i)),
         .ctrl        (ctrl),
         .left_value  (left_value[i]),
         .right_value (right_value[i]),
         .value       (cell_value[i])
      );
   end

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign len_ext  = {{(POS_W-CNT_W){1'b0}}, len_ff};
   assign is_full  = (len_ff >= CNT_W'(plc_pkg::CAPACITY));

   // clamp the request indices against the current length
   assign ins_idx = (req_chan.position > len_ext) ? len_ff[IDX_W-1:0]
                                                  : req_chan.position[IDX_W-1:0];
   assign erase_skip = (len_ff == '0) || (req_chan.position == req_chan.end_position)
                       || (req_chan.position >= len_ext);
   assign erase_stop = ((req_chan.end_position < req_chan.position)
                        || (req_chan.end_position > len_ext))
                       ? len_ff : req_chan.end_position[CNT_W-1:0];
   assign print_idx  = (req_chan.position >= len_ext) ? (len_ff - 1'b1)
                                                      : req_chan.position[CNT_W-1:0];

   // One pass rotates the list through cell 0: each step pops the head, shifts the row
   // down, and appends the head behind the entries already kept when it survives.
   assign step      = (state_ff == ST_PASS) && out_free;
   assign head      = cell_value[0];
   assign in_range  = (step_ff >= first_ff) && (step_ff < stop_ff);
   assign last_step = (step_ff == (len_ff - 1'b1));
   assign write_cnt = len_ff - step_ff - 1'b1 + kept_ff;
   assign kept_next = kept_ff + {{(CNT_W-1){1'b0}}, keep};

   always_comb begin
      unique case (op_ff)
         plc_pkg::OP_REMOVE: keep = (head != val_ff);
         plc_pkg::OP_ERASE:  keep = !in_range;
         default:            keep = 1'b1;
      endcase
   end

   assign emit = (op_ff == plc_pkg::OP_SHOW)
                 || ((op_ff == plc_pkg::OP_PRINT) && (step_ff == first_ff));

   always_comb begin
      ctrl.mode      = plc_pkg::CELL_HOLD;
      ctrl.ins_idx   = ins_idx;
      ctrl.ins_value = req_chan.value;
      ctrl.write_idx = write_cnt[IDX_W-1:0];
      ctrl.keep      = keep;
      ctrl.head      = head;
      if (accept && (req_chan.op == plc_pkg::OP_INSERT) && !is_full) begin
         ctrl.mode = plc_pkg::CELL_INSERT;
      end else if (step) begin
         ctrl.mode = plc_pkg::CELL_ROTATE;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      step_in       = step_ff;
      kept_in       = kept_ff;
      op_in         = op_ff;
      first_in      = first_ff;
      stop_in       = stop_ff;
      val_in        = val_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_chan.op;
               val_in   = req_chan.value;
               first_in = req_chan.position[CNT_W-1:0];
               stop_in  = erase_stop;
               step_in  = '0;
               kept_in  = '0;
               unique case (req_chan.op)
                  plc_pkg::OP_INSERT: begin
                     if (is_full) begin
                        state_in = ST_FULL;
                     end else begin
                        len_in = len_ff + 1'b1;
                     end
                  end
                  plc_pkg::OP_ERASE: begin
                     if (!erase_skip) begin
                        state_in = ST_PASS;
                     end
                  end
                  plc_pkg::OP_PRINT: begin
                     first_in = print_idx;
                     if (len_ff != '0) begin
                        state_in = ST_PASS;
                     end
                  end
                  plc_pkg::OP_REMOVE, plc_pkg::OP_SHOW: begin
                     if (len_ff != '0) begin
                        state_in = ST_PASS;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_PASS: begin
            if (step) begin
               step_in = step_ff + 1'b1;
               kept_in = kept_next;
               if (emit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = head;
                  rsp_last_in   = (op_ff == plc_pkg::OP_PRINT) || last_step;
                  rsp_status_in = 1'b0;
               end
               if (last_step) begin
                  len_in   = kept_next;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FULL: begin
            // report the dropped insert
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         step_ff      <= '0;
         kept_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         step_ff      <= step_in;
         kept_ff      <= kept_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and context hold without reset
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      first_ff      <= first_in;
      stop_ff       <= stop_in;
      val_ff        <= val_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   // take no request while reset is held
   assign req_chan.ready      = (state_ff == ST_IDLE) && !reset;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.item_value = rsp_value_ff;
   assign rsp_chan.last_item  = rsp_last_ff;
   assign rsp_chan.status     = rsp_status_ff;

endmodule

/* sv/plc_cell.sv */
// One storage cell of the list row: holds one entry and trades with neighbors.
// Depends on plc_pkg for widths, mode codes and the control struct.
module plc_cell (
   input  logic                       clock,
   input  logic [plc_pkg::IDX_W-1:0]  cell_idx,
   input  plc_pkg::cell_ctrl_type     ctrl,
   input  logic [plc_pkg::DATA_W-1:0] left_value,
   input  logic [plc_pkg::DATA_W-1:0] right_value,
   output logic [plc_pkg::DATA_W-1:0] value
);

   logic [plc_pkg::DATA_W-1:0] value_ff;
   logic [plc_pkg::DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      unique case (ctrl.mode)
         plc_pkg::CELL_INSERT: begin
            // open a slot at the insert index, push later entries up
            if (cell_idx == ctrl.ins_idx) begin
               value_in = ctrl.ins_value;
            end else if (cell_idx > ctrl.ins_idx) begin
               value_in = left_value;
            end
         end
         plc_pkg::CELL_ROTATE: begin
            // advance the row down by one, append the head at the write slot
            if (ctrl.keep && (cell_idx == ctrl.write_idx)) begin
               value_in = ctrl.head;
            end else begin
               value_in = right_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

/* sim/positional_list_editor_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for positional_list_editor: random-idling driver and monitor,
// a shadow list that predicts every response. Depends on plc_pkg, plc_req_if, plc_rsp_if.
module positional_list_editor_test;

   localparam int CAPACITY = plc_pkg::CAPACITY;
   localparam int IDX_W    = plc_pkg::IDX_W;
   localparam int CNT_W    = plc_pkg::CNT_W;
   localparam int DATA_W   = plc_pkg::DATA_W;
   localparam int POS_W    = plc_pkg::POS_W;
   localparam int OP_W     = plc_pkg::OP_W;

   // Op codes the block must ignore.
   localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 2 * CAPACITY + 10;
   localparam int LONG_HOLD     = 400;
   localparam int PHASE1_AT     = 40;
   localparam int PHASE2_AT     = 80;
   localparam int SHOWN_ERRORS  = 10;
   localparam int MIXED_COUNT   = 8;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [POS_W-1:0]  position;
      logic [POS_W-1:0]  end_position;
      logic [DATA_W-1:0] value;
      logic              drain_first;   // hold this request until all responses are in
   } list_request_type;

   typedef struct packed {
      logic [DATA_W-1:0] item_value;
      logic              last_item;
      logic              status;
   } list_result_type;

   logic clock;
   logic reset;

   plc_req_if req_bus ();
   plc_rsp_if rsp_bus ();

   positional_list_editor dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Stimulus waiting to be offered, and responses owed by the block.
   list_request_type pending_requests[$];
   list_result_type  owed_results[$];

   // Shadow copy of the list, advanced at each accepted request.
   logic [DATA_W-1:0] shadow_list [CAPACITY];
   logic [CNT_W-1:0]  shadow_length;

   int requests_accepted = 0;   // advanced by the driver, nonblocking
   int results_predicted = 0;   // driver only
   int results_checked   = 0;   // advanced by the monitor, nonblocking
   int mismatch_count    = 0;
   int cycle_count       = 0;
   int hold_left         = 0;
   logic hold_started    = 1'b0;
   int hold_trigger_at   = -1;

   // Idle rate per side: sender light / receiver heavy first, then swapped,
   // then a clean stretch with no idling at all.
   function automatic int idle_percent(input logic receiver_side, input int accepted);
      if (accepted < PHASE1_AT) return receiver_side ? 47 : 37;
      if (accepted < PHASE2_AT) return receiver_side ? 37 : 47;
      return 0;
   endfunction

   function automatic void owe_result(input logic [DATA_W-1:0] v, input logic last,
                                      input logic st);
      list_result_type r;
      r.item_value = v;
      r.last_item  = last;
      r.status     = st;
      owed_results.push_back(r);
      results_predicted++;
   endfunction

   // Apply one accepted request to the shadow list and queue its responses.
   function automatic void predict_request(input list_request_type rq);
      int unsigned len;
      int unsigned first;
      int unsigned stop;
      int unsigned kept;
      int unsigned i;
      len = 32'(shadow_length);
      case (rq.op)
         plc_pkg::OP_INSERT: begin
            if (len >= CAPACITY) begin
               // full list: drop the value and flag it
               owe_result('0, 1'b1, 1'b1);
            end else begin
               first = (rq.position > len) ? len : 32'(rq.position);
               for (i = len; i > first; i--)
                  shadow_list[IDX_W'(i)] = shadow_list[IDX_W'(i - 1)];
               shadow_list[IDX_W'(first)] = rq.value;
               shadow_length = CNT_W'(len + 1);
            end
         end
         plc_pkg::OP_ERASE: begin
            if (len != 0 && rq.position != rq.end_position && rq.position < len) begin
               first = 32'(rq.position);
               // a reversed or overlong range runs to the end of the list
               stop = (rq.end_position < rq.position || rq.end_position > len) ?
                      len : 32'(rq.end_position);
               for (i = stop; i < len; i++)
                  shadow_list[IDX_W'(first + i - stop)] = shadow_list[IDX_W'(i)];
               shadow_length = CNT_W'(len - (stop - first));
            end
         end
         plc_pkg::OP_PRINT: begin
            if (len != 0) begin
               first = (rq.position > len - 1) ? len - 1 : 32'(rq.position);
               owe_result(shadow_list[IDX_W'(first)], 1'b1, 1'b0);
            end
         end
         plc_pkg::OP_REMOVE: begin
            kept = 0;
            for (i = 0; i < len; i++) begin
               if (shadow_list[IDX_W'(i)] != rq.value) begin
                  shadow_list[IDX_W'(kept)] = shadow_list[IDX_W'(i)];
                  kept++;
               end
            end
            shadow_length = CNT_W'(kept);
         end
         plc_pkg::OP_SHOW: begin
            for (i = 0; i < len; i++)
               owe_result(shadow_list[IDX_W'(i)], (i + 1 == len), 1'b0);
         end
         default: ;   // spare codes change nothing
      endcase
   endfunction

   function automatic void flag_mismatch(input string why, input list_result_type want,
                                         input list_result_type got);
      mismatch_count++;
      if (mismatch_count <= SHOWN_ERRORS)
         $display("response mismatch (%s): expected value %h last %b status %b, got %h %b %b",
                  why, want.item_value, want.last_item, want.status,
                  got.item_value, got.last_item, got.status);
   endfunction

   // ---------------------------------------------------------------- driver
   // Hold a request until it is taken; on acceptance, advance the shadow list.
   // A request marked drain_first waits until every owed response is checked.
   always @(posedge clock) begin
      list_request_type taken;
      list_request_type next_req;
      logic             may_offer;
      if (reset) begin
         req_bus.valid        <= 1'b0;
         req_bus.op           <= plc_pkg::OP_INSERT;
         req_bus.position     <= '0;
         req_bus.end_position <= '0;
         req_bus.value        <= '0;
         shadow_length         = '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            taken.op           = req_bus.op;
            taken.position     = req_bus.position;
            taken.end_position = req_bus.end_position;
            taken.value        = req_bus.value;
            taken.drain_first  = 1'b0;
            predict_request(taken);
            requests_accepted <= requests_accepted + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            may_offer = 1'b0;
            if (pending_requests.size() != 0) begin
               if ($urandom_range(99) >= idle_percent(1'b0, requests_accepted))
                  may_offer = !pending_requests[0].drain_first ||
                              results_checked == results_predicted;
            end
            req_bus.valid <= may_offer;
            if (may_offer) begin
               next_req = pending_requests.pop_front();
               req_bus.op           <= next_req.op;
               req_bus.position     <= next_req.position;
               req_bus.end_position <= next_req.end_position;
               req_bus.value        <= next_req.value;
            end
         end
      end
   end

   // ---------------------------------------------------------------- long hold
   // Drop ready for a long stretch once the big show is next, so the block
   // backs up and stalls the request side while the driver keeps offering.
   always @(posedge clock) begin
      if (reset) begin
         hold_left    <= 0;
         hold_started <= 1'b0;
      end else if (!hold_started && requests_accepted == hold_trigger_at) begin
         hold_left    <= LONG_HOLD;
         hold_started <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ---------------------------------------------------------------- monitor
   // Check each accepted response against the oldest owed one, field by field.
   always @(posedge clock) begin
      list_result_type got;
      list_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.item_value = rsp_bus.item_value;
            got.last_item  = rsp_bus.last_item;
            got.status     = rsp_bus.status;
            if (owed_results.size() == 0) begin
               flag_mismatch("unexpected", '0, got);
            end else begin
               want = owed_results.pop_front();
               results_checked <= results_checked + 1;
               if (got.item_value !== want.item_value || got.last_item !== want.last_item ||
                   got.status !== want.status)
                  flag_mismatch("wrong field", want, got);
            end
         end
         rsp_bus.ready <= (hold_left == 0) &&
                          ($urandom_range(99) >= idle_percent(1'b1, requests_accepted));
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", CYCLE_LIMIT);
         $display("positional_list_editor regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus
   function automatic void add_request(input logic [OP_W-1:0] op,
                                       input logic [POS_W-1:0] pos,
                                       input logic [POS_W-1:0] endp,
                                       input logic [DATA_W-1:0] val,
                                       input logic drain);
      list_request_type r;
      r.op           = op;
      r.position     = pos;
      r.end_position = endp;
      r.value        = val;
      r.drain_first  = drain;
      pending_requests.push_back(r);
   endfunction

   function automatic logic [POS_W-1:0] rand_pos();
      return POS_W'($urandom());
   endfunction

   function automatic logic [DATA_W-1:0] rand_value();
      return DATA_W'($urandom());
   endfunction

   // Mostly indices inside the list, sometimes anywhere in the 16-bit range.
   function automatic logic [POS_W-1:0] pick_position(input int est_len);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) return POS_W'($urandom_range(est_len));
      if (roll < 85) return rand_pos();
      return roll[0] ? '1 : '0;
   endfunction

   // A small pool of repeated values makes remove-equal hit several entries.
   function automatic logic [DATA_W-1:0] pick_value();
      if ($urandom_range(99) < 40) begin
         case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h00FF;
            3: return 16'hFF00;
            4: return 16'h5A5A;
            default: return 16'hA5A5;
         endcase
      end
      return rand_value();
   endfunction

   initial begin
      int est_len;
      int inserts_done;
      int mixed_done;
      int unsigned roll;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] endp;
      int stop;

      reset = 1'b1;

      // Directed part: empty list, clamping, every erase corner, spare codes.
      add_request(plc_pkg::OP_SHOW,   16'h0000, 16'h0000, 16'h0000, 1'b0);   // empty list
      add_request(plc_pkg::OP_PRINT,  16'h0000, 16'h0000, 16'h0000, 1'b0);   // empty list
      add_request(plc_pkg::OP_ERASE,  16'h0000, 16'hFFFF, 16'h0000, 1'b0);   // empty list
      add_request(plc_pkg::OP_INSERT, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);   // past the end
      add_request(plc_pkg::OP_INSERT, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      add_request(plc_pkg::OP_INSERT, 16'h0001, 16'h0000, 16'h5A5A, 1'b0);
      add_request(plc_pkg::OP_INSERT, 16'hFFFF, 16'h0000, 16'hA5A5, 1'b0);
      add_request(plc_pkg::OP_PRINT,  16'hFFFF, 16'h0000, 16'h0000, 1'b0);   // last entry
      add_request(plc_pkg::OP_PRINT,  16'h0000, 16'h0000, 16'h0000, 1'b0);
      add_request(plc_pkg::OP_SHOW,   16'h0000, 16'h0000, 16'h0000, 1'b0);
      add_request(plc_pkg::OP_ERASE,  16'h0001, 16'h0001, 16'h0000, 1'b0);   // equal bounds
      add_request(plc_pkg::OP_ERASE,  16'h0004, 16'h0009, 16'h0000, 1'b0);   // start past end
      add_request(plc_pkg::OP_ERASE,  16'hFFFF, 16'h0000, 16'h0000, 1'b0);
      add_request(OP_SPARE_5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      add_request(OP_SPARE_6, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      add_request(OP_SPARE_7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      add_request(plc_pkg::OP_ERASE,  16'h0003, 16'hFFFF, 16'h0000, 1'b0);   // end clipped
      add_request(plc_pkg::OP_INSERT, 16'h0003, 16'h0000, 16'h5A5A, 1'b0);
      add_request(plc_pkg::OP_INSERT, 16'h0001, 16'h0000, 16'h1234, 1'b0);
      add_request(plc_pkg::OP_ERASE,  16'h0002, 16'h0001, 16'h0000, 1'b0);   // reversed
      add_request(plc_pkg::OP_INSERT, 16'h0002, 16'h0000, 16'h5A5A, 1'b0);
      add_request(plc_pkg::OP_INSERT, 16'h0000, 16'h0000, 16'h5A5A, 1'b0);
      add_request(plc_pkg::OP_REMOVE, 16'h0000, 16'h0000, 16'h5A5A, 1'b0);
      add_request(plc_pkg::OP_SHOW,   16'h0000, 16'h0000, 16'h0000, 1'b0);
      add_request(plc_pkg::OP_REMOVE, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      est_len = 1;

      // Fill burst: enough inserts to pass capacity and hit the full-list drop,
      // with prints sprinkled in. Start it only once the directed part drained.
      inserts_done = 0;
      while (inserts_done < CAPACITY + 6) begin
         if ($urandom_range(9) == 0) begin
            add_request(plc_pkg::OP_PRINT, pick_position(est_len), rand_pos(),
                        rand_value(), inserts_done == 0);
         end else begin
            add_request(plc_pkg::OP_INSERT, pick_position(est_len), rand_pos(),
                        pick_value(), inserts_done == 0);
            if (est_len < CAPACITY) est_len++;
            inserts_done++;
         end
      end

      // Show the full list under a long receiver hold.
      hold_trigger_at = pending_requests.size();
      add_request(plc_pkg::OP_SHOW, rand_pos(), rand_pos(), rand_value(), 1'b0);

      // Mixed traffic; the first one waits for every response to come back.
      mixed_done = 0;
      while (mixed_done < MIXED_COUNT) begin
         roll = $urandom_range(99);
         pos  = pick_position(est_len);
         if (roll < 28) begin
            add_request(plc_pkg::OP_INSERT, pos, rand_pos(), pick_value(), mixed_done == 0);
            if (est_len < CAPACITY) est_len++;
         end else if (roll < 50) begin
            case ($urandom_range(3))
               0: endp = POS_W'(pos + $urandom_range(8));
               1: endp = POS_W'($urandom_range(pos));
               2: endp = rand_pos();
               default: endp = POS_W'(pos + $urandom_range(3, 1));
            endcase
            add_request(plc_pkg::OP_ERASE, pos, endp, rand_value(), mixed_done == 0);
            if (est_len != 0 && pos != endp && pos < est_len) begin
               stop = (endp < pos || endp > est_len) ? est_len : int'(endp);
               est_len -= stop - int'(pos);
            end
         end else if (roll < 66) begin
            add_request(plc_pkg::OP_PRINT, pos, rand_pos(), rand_value(), mixed_done == 0);
         end else if (roll < 78) begin
            add_request(plc_pkg::OP_REMOVE, rand_pos(), rand_pos(), pick_value(),
                        mixed_done == 0);
            est_len = est_len / 2;
         end else if (roll < 88) begin
            add_request(plc_pkg::OP_SHOW, pos, rand_pos(), rand_value(), mixed_done == 0);
         end else begin
            // spare code: ignored by the block, so not counted
            add_request(OP_W'($urandom_range(OP_SPARE_7, OP_SPARE_5)), pos,
                        rand_pos(), rand_value(), 1'b0);
            mixed_done--;
         end
         mixed_done++;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last request to go in and every owed response to come out,
      // then let the block settle before judging.
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_bus.valid || owed_results.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && owed_results.size() == 0) begin
         $display("positional_list_editor regression: pass");
      end else begin
         $display("positional_list_editor regression: fail");
      end
      $finish;
   end

endmodule
